@@ hw/rtl/kflc_pkg.sv @@
// Shared types and constants for the lag-compensated Kalman filter.
// No dependencies.
`default_nettype none
package kflc_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned LagW = 18;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEASURE_NOISE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LAG_RATIO = 2'd3;

  localparam logic [31:0] RST_PROCESS_NOISE = 32'd66;
  localparam logic [31:0] RST_MEASURE_NOISE = 32'd65536;
  localparam logic [31:0] RST_STEP_TIME = 32'd655;
  localparam logic [17:0] RST_LAG_RATIO = 18'd26214;
  localparam logic [31:0] RST_VARIANCE = 32'd65536;

  localparam logic [15:0] W_OLD = 16'd45875;
  localparam logic [15:0] W_NEW = 16'd19661;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAIN, ST_GAIN_WAIT, ST_FILT, ST_VAR, ST_RAW, ST_RAW_WAIT,
    ST_SPD_OLD, ST_SPD_NEW, ST_LAG_HI, ST_LAG_LO, ST_LAG_HI2, ST_DONE
  } kflc_state_t;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } kflc_div_req_t;
endpackage
`default_nettype wire

@@ hw/rtl/kflc_if.sv @@
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface kflc_if #(parameter int unsigned W = 32);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/kflc_div.sv @@
// Restoring divider, one quotient bit per cycle, 64 by 33 bits.
// Depends on kflc_pkg.
`default_nettype none
module kflc_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire kflc_pkg::kflc_div_req_t req,
  output logic                        busy,
  output logic [63:0]                 quot
);
  import kflc_pkg::*;
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dsr_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic [33:0] trial;

  always_comb begin
    trial = {rem_r, q_r[63]};
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (cnt_r != 7'd0) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 33'(trial - {1'b0, dsr_r});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= 7'd64;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != 7'd0);
  assign quot = q_r;
endmodule
`default_nettype wire

@@ hw/rtl/kalman_filter_lag_compensated.sv @@
// Scalar Kalman filter with velocity-lag compensation, signed Q16.16. One
// measurement in, one result out. Each item waits twice on the shared
// bit-serial divider (gain, then speed); the other sequencer steps reuse
// one 33x33 signed multiplier. A zero gain denominator or a zero step time
// skips its divide.
// in_ready is high only while idle with no result pending transfer.
// Write configuration only between items; a write during an item alters it.
`default_nettype none
module kalman_filter_lag_compensated (
  input  wire logic clk,
  input  wire logic rst_n,
  kflc_if.sink      in_ch,
  kflc_if.source    out_ch,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [kflc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import kflc_pkg::*;

  logic [31:0] q_r, r_r, dt_r;
  logic [LagW-1:0] lag_r;
  logic signed [31:0] est_r, spd_r, z_r, filt_r;
  logic [31:0] var_r, pp_r;
  logic [16:0] k_r;
  logic sat_r, ovalid_r;
  logic signed [31:0] comp_r;
  logic signed [66:0] acc_r, acc_nxt;
  logic signed [32:0] raw_r;
  kflc_state_t st_r, st_nxt;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  kflc_div_req_t dreq;
  logic dbusy;
  logic [63:0] dquot;

  kflc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dquot));

  assign prod = ma * mb;

  // rounding helper: magnitude to nearest, ties away
  function automatic logic signed [66:0] rnd16(input logic signed [66:0] v);
    logic [66:0] m;
    m = v[66] ? -v : v;
    m = (m + 67'd32768) >> 16;
    return v[66] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [66:0] v, output logic s);
    s = 1'b0;
    if (v > 67'sd2147483647) begin
      s = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -67'sd2147483648) begin
      s = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic [32:0] pp_sum;
  logic [32:0] den;
  logic signed [32:0] delta;
  logic [32:0] dmag;

  assign pp_sum = {1'b0, var_r} + {1'b0, q_r};
  assign den = {1'b0, pp_r} + {1'b0, r_r};
  assign delta = {filt_r[31], filt_r} - {est_r[31], est_r};
  assign dmag = delta[32] ? -delta : delta;
  assign cfg_ready = 1'b1;
  assign in_ch.ready = (st_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = {comp_r, filt_r, sat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= RST_PROCESS_NOISE;
      r_r <= RST_MEASURE_NOISE;
      dt_r <= RST_STEP_TIME;
      lag_r <= RST_LAG_RATIO;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PROCESS_NOISE: q_r <= cfg_data;
        CFG_MEASURE_NOISE: r_r <= cfg_data;
        CFG_STEP_TIME: dt_r <= cfg_data;
        CFG_LAG_RATIO: lag_r <= cfg_data[LagW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    ma = '0;
    mb = '0;
    acc_nxt = acc_r;
    dreq = '0;
    case (st_r)
      ST_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = ST_GAIN;
      ST_GAIN: begin
        if (den != 33'd0) begin
          dreq.start = 1'b1;
          dreq.dividend = {16'd0, pp_r, 16'd0};
          dreq.divisor = den;
        end
        st_nxt = ST_GAIN_WAIT;
      end
      ST_GAIN_WAIT: if (!dbusy) st_nxt = ST_FILT;
      ST_FILT: begin
        ma = {16'd0, k_r};
        mb = {z_r[31], z_r} - {est_r[31], est_r};
        st_nxt = ST_VAR;
      end
      ST_VAR: begin
        ma = $signed({16'd0, 17'd65536 - k_r});
        mb = $signed({1'b0, pp_r});
        st_nxt = ST_RAW;
      end
      ST_RAW: begin
        if (dt_r != 32'd0) begin
          dreq.start = 1'b1;
          dreq.dividend = {15'd0, dmag, 16'd0};
          dreq.divisor = {1'b0, dt_r};
        end
        st_nxt = ST_RAW_WAIT;
      end
      ST_RAW_WAIT: if (!dbusy) st_nxt = ST_SPD_OLD;
      ST_SPD_OLD: begin
        ma = {spd_r[31], spd_r};
        mb = $signed({17'd0, W_OLD});
        acc_nxt = 67'(prod);
        st_nxt = ST_SPD_NEW;
      end
      ST_SPD_NEW: begin
        ma = raw_r;
        mb = $signed({17'd0, W_NEW});
        st_nxt = ST_LAG_HI;
      end
      ST_LAG_HI: begin
        // |speed| * dt, then split against the lag ratio
        ma = $signed({1'b0, spd_r[31] ? 32'(-spd_r) : spd_r});
        mb = $signed({1'b0, dt_r});
        acc_nxt = 67'(prod);
        st_nxt = ST_LAG_LO;
      end
      ST_LAG_LO: begin
        ma = $signed({1'b0, acc_r[31:0]});
        mb = $signed({15'd0, lag_r});
        st_nxt = ST_LAG_HI2;
      end
      ST_LAG_HI2: begin
        ma = $signed({1'b0, acc_r[63:32]});
        mb = $signed({15'd0, lag_r});
        st_nxt = ST_DONE;
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic signed [66:0] lo_part;
  always_ff @(posedge clk) begin
    logic signed [66:0] tmp;
    logic csat;
    logic signed [31:0] cv;
    logic [63:0] qsat;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ovalid_r <= 1'b0;
      est_r <= '0;
      var_r <= RST_VARIANCE;
      spd_r <= '0;
    end else begin
      st_r <= st_nxt;
      acc_r <= acc_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          z_r <= in_ch.data;
          sat_r <= pp_sum[32];
          pp_r <= pp_sum[32] ? 32'hffffffff : pp_sum[31:0];
        end
        ST_GAIN_WAIT: if (!dbusy) k_r <= (den == 33'd0) ? 17'd0 : dquot[16:0];
        ST_FILT: begin
          filt_r <= clip(67'(est_r) + rnd16(67'(prod)), csat);
        end
        ST_VAR: begin
          tmp = rnd16(67'(prod));
          var_r <= (tmp > 67'sh0ffffffff) ? 32'hffffffff : tmp[31:0];
        end
        ST_RAW_WAIT: if (!dbusy) begin
          if (dt_r == 32'd0) begin
            raw_r <= delta[32] ? -33'sd2147483648 :
                     (delta == 33'sd0 ? 33'sd0 : 33'sd2147483647);
            if (delta != 33'sd0) sat_r <= 1'b1;
          end else begin
            qsat = (dquot > 64'h80000000) ? 64'h80000000 : dquot;
            if (delta[32]) begin
              raw_r <= -$signed({1'b0, qsat[31:0]});
            end else if (qsat > 64'h7fffffff) begin
              raw_r <= 33'sd2147483647;
              sat_r <= 1'b1;
            end else begin
              raw_r <= $signed({1'b0, qsat[31:0]});
            end
          end
        end
        ST_SPD_NEW: begin
          cv = clip(rnd16(acc_r + 67'(prod)), csat);
          spd_r <= cv;
          if (csat) sat_r <= 1'b1;
        end
        ST_LAG_LO: lo_part <= (67'(prod) + 67'sh80000000) >>> 32;
        ST_LAG_HI2: begin
          tmp = 67'(prod) + lo_part;
          if (spd_r[31]) tmp = -tmp;
          comp_r <= clip(67'(filt_r) + tmp, csat);
          if (csat) sat_r <= 1'b1;
          est_r <= filt_r;
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking bench for the lag-compensated scalar Kalman filter.
// Uses kflc_pkg and kflc_if from the RTL. A bit-exact predictor checks each result.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kflc_pkg::*;

  typedef struct packed {
    logic [31:0] compensated;
    logic [31:0] filtered;
    logic        saturated;
  } kf_result_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;

  kflc_if #(.W(32)) in_ch ();
  kflc_if #(.W(65)) out_ch ();

  kalman_filter_lag_compensated u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // predictor copy of configuration and state
  logic [31:0] q_noise, r_noise, dt_reg;
  logic [17:0] lag_reg;
  int          est_st;
  logic [31:0] var_st;
  int          spd_st;

  logic [31:0] meas_pending[$];
  kf_result_t  results_due[$];
  int          in_cnt;
  int          err_cnt;
  logic        in_fire;
  int          sig_walk;

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint rnd16(input longint v);
    logic [63:0] r;
    r = (mag64(v) + 64'd32768) >> 16;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip32(input longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic kalman_update(input logic [31:0] z, output kf_result_t res);
    bit          s;
    longint      x, zz, filt, delta, raw, spd, lagt, comp, pv;
    logic [63:0] pp, den, k, q, m, hi, lo, lm;
    s = 1'b0;
    zz = longint'(int'(z));
    x = longint'(est_st);
    pp = {32'b0, var_st} + {32'b0, q_noise};
    if (pp > 64'hFFFF_FFFF) begin
      pp = 64'hFFFF_FFFF;
      s = 1'b1;
    end
    den = pp + {32'b0, r_noise};
    k = (den != 0) ? (pp << 16) / den : 64'd0;
    filt = clip32(x + rnd16(longint'(k) * (zz - x)), s);
    pv = rnd16(longint'((64'd65536 - k) * pp));
    if (pv > 64'sh0_FFFF_FFFF) pv = 64'sh0_FFFF_FFFF;
    delta = filt - x;
    if (dt_reg == 0) begin
      raw = delta > 0 ? 64'sd2147483647 : (delta < 0 ? -64'sd2147483648 : 64'sd0);
      if (delta != 0) s = 1'b1;
    end else begin
      q = (mag64(delta) << 16) / {32'b0, dt_reg};
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      raw = clip32(delta < 0 ? -longint'(q) : longint'(q), s);
    end
    spd = clip32(rnd16(longint'(W_OLD) * longint'(spd_st) + longint'(W_NEW) * raw), s);
    m = mag64(spd) * {32'b0, dt_reg};
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    lm = hi * {46'b0, lag_reg} + ((lo * {46'b0, lag_reg} + 64'h8000_0000) >> 32);
    lagt = spd < 0 ? -longint'(lm) : longint'(lm);
    comp = clip32(filt + lagt, s);
    est_st = int'(filt);
    var_st = pv[31:0];
    spd_st = int'(spd);
    res.compensated = comp[31:0];
    res.filtered = filt[31:0];
    res.saturated = s;
  endtask

  function automatic int sender_idle_pct();
    if (in_cnt < 650) return 30;
    if (in_cnt < 1300) return 68;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (in_cnt < 650) return 68;
    if (in_cnt < 1300) return 30;
    return 0;
  endfunction

  // driver: hold the item until it transfers
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_fire) begin
        if (meas_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= meas_pending[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    kf_result_t exp_r, got_r;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      kalman_update(in_ch.data, exp_r);
      results_due.push_back(exp_r);
      void'(meas_pending.pop_front());
      in_cnt <= in_cnt + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_r = out_ch.data;
      if (results_due.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < 10) $display("unexpected result %h", got_r);
      end else begin
        exp_r = results_due.pop_front();
        if (got_r !== exp_r) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10)
            $display("mismatch comp %h/%h filt %h/%h sat %b/%b (exp/got)",
                     exp_r.compensated, got_r.compensated, exp_r.filtered,
                     got_r.filtered, exp_r.saturated, got_r.saturated);
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROCESS_NOISE: q_noise = val;
      CFG_MEASURE_NOISE: r_noise = val;
      CFG_STEP_TIME:     dt_reg = val;
      CFG_LAG_RATIO:     lag_reg = val[17:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (meas_pending.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_filter(input logic [31:0] qn, input logic [31:0] rn,
                            input logic [31:0] dt, input logic [31:0] lag);
    drain();
    write_reg(CFG_PROCESS_NOISE, qn);
    write_reg(CFG_MEASURE_NOISE, rn);
    write_reg(CFG_STEP_TIME, dt);
    write_reg(CFG_LAG_RATIO, lag);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_meas();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      // slowly moving signal with noise, the normal sensor case
      sig_walk += int'($urandom_range(4000)) - 2000;
      return 32'(sig_walk + int'($urandom_range(65536)) - 32768);
    end
    if (sel < 85) return $urandom;
    if (sel < 92) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return 32'(int'($urandom_range(131072)) - 65536);
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(3))
      0: return $urandom_range(1000);
      1: return $urandom_range(1 << 20);
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  initial begin
    logic [31:0] rn, dt;
    logic [31:0] corner_meas[8];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    in_cnt = 0;
    err_cnt = 0;
    sig_walk = 0;
    q_noise = RST_PROCESS_NOISE;
    r_noise = RST_MEASURE_NOISE;
    dt_reg = RST_STEP_TIME;
    lag_reg = RST_LAG_RATIO;
    est_st = 0;
    var_st = RST_VARIANCE;
    spd_st = 0;
    corner_meas = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, field extremes
    foreach (corner_meas[i])
      meas_pending.push_back(corner_meas[i]);
    // zero noise drives the variance to zero, then the gain denominator is zero
    set_filter(32'h0, 32'h0, 32'd655, 32'd131072);
    meas_pending.push_back(32'h0010_0000);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h0);
    // zero step time, saturating predicted variance, lag ratio above 2.0
    set_filter(32'hFFFF_FFFF, 32'h1, 32'h0, 32'd262143);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h0);
    // widest step time and noise, no compensation
    set_filter(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    set_filter(32'h0001_0000, 32'h1, 32'h1, 32'd262143);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h1234_5678);

    repeat (12) begin
      rn = ($urandom_range(9) == 0) ? 32'h0 : pick_noise();
      case ($urandom_range(3))
        0: dt = $urandom;
        1: dt = 32'h0;
        default: dt = $urandom_range(1, 65536);
      endcase
      set_filter(pick_noise(), rn, dt, $urandom_range(262143));
      sig_walk = int'($urandom);
      repeat (161) meas_pending.push_back(pick_meas());
    end

    drain();
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && results_due.size() == 0) begin
      $display("[kalman_filter_lag_compensated] OK");
    end else begin
      $display("[kalman_filter_lag_compensated] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[kalman_filter_lag_compensated] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
